// ----- src/maf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_pkg
// shared widths and constants of the boxcar moving average
// ----------------------------------------------------------------------------
package maf_pkg;

  // fixed field widths
  localparam int TOTAL_BITS = 22;
  localparam int MEAN_BITS  = 16;
  localparam int TS_BITS    = 32;
  localparam int WL_BITS    = 7;

  // window length after reset
  localparam logic [WL_BITS-1:0] WL_RESET = 7'd4;

  typedef logic [TOTAL_BITS-1:0] total_mag_t;

endpackage

// ----- src/maf_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maf_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module maf_divider import maf_pkg::*; #(
  parameter int DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  total_mag_t       dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output total_mag_t       quotient_o
);

  localparam int CNT_W = $clog2(TOTAL_BITS + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  total_mag_t       dvd_q, dvd_d;
  logic [DVS_W:0]   rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_q[DVS_W-1:0], dvd_q[TOTAL_BITS-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(TOTAL_BITS);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      dvd_d = {dvd_q[TOTAL_BITS-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ----- src/moving_average_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moving_average_filter_core
// boxcar moving average: sum and truncated mean of the last window_length
// samples, kept in a circular history memory
// ----------------------------------------------------------------------------
//  channel   signals                                         direction
//  -------   ----------------------------------------------  ---------
//  input     in_valid_i/in_ready_o, sample_i, time_stamp_i,  in
//            start_record_i
//  output    out_valid_o/out_ready_i, time_stamp_out_o,      out
//            window_total_o, mean_o
//  config    cfg_we_i, cfg_wdata_i (window_length)           in
//
//  an item is taken only in the idle step and passes the store, read,
//  saturate, divide and output steps before the next one is taken; the
//  read step makes used reads, used being the smaller of the clamped
//  window length and the samples stored in this record, one read per cycle
//  on the single memory read port; the mean comes from the bit-serial divider
//  reset clears the pointers, fill count and handshakes; the history needs
//  no clearing, only slots written in the current record are read
//  a result waiting on out_ready_i does not stop the next item being taken;
//  that item holds in its last step until the output register is free
// ----------------------------------------------------------------------------
module moving_average_filter_core import maf_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [WL_BITS-1:0]            cfg_wdata_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [TS_BITS-1:0]            time_stamp_i,
  input  logic                          start_record_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [TS_BITS-1:0]            time_stamp_out_o,
  output logic signed [TOTAL_BITS-1:0]  window_total_o,
  output logic signed [MEAN_BITS-1:0]   mean_o
);

  // widths following from the parameters
  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int N_W    = $clog2(WINDOW_MAX + 1);
  localparam int L_W    = (N_W > WL_BITS) ? N_W : WL_BITS;
  localparam int ACC_W  = SAMPLE_BITS + N_W + 1;
  localparam int EXT_W  = (ACC_W > TOTAL_BITS) ? ACC_W : TOTAL_BITS;

  localparam logic signed [EXT_W-1:0] TOT_MAX = EXT_W'(2 ** (TOTAL_BITS - 1) - 1);
  localparam logic signed [EXT_W-1:0] TOT_MIN = -TOT_MAX - EXT_W'(1);
  localparam total_mag_t MEAN_POS_LIM = TOTAL_BITS'(2 ** (MEAN_BITS - 1) - 1);
  localparam total_mag_t MEAN_NEG_LIM = TOTAL_BITS'(2 ** (MEAN_BITS - 1));
  localparam logic [MEAN_BITS-1:0] MEAN_MAX = {1'b0, {(MEAN_BITS-1){1'b1}}};
  localparam logic [MEAN_BITS-1:0] MEAN_MIN = {1'b1, {(MEAN_BITS-1){1'b0}}};

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STORE = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SAT   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic [WL_BITS-1:0]          wl_q;
  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [TS_BITS-1:0]          ts_q, ts_d;
  logic                        start_q, start_d;
  logic [N_W-1:0]              n_q, n_d;
  logic [SLOT_W-1:0]           slot_q, slot_d;
  logic [N_W-1:0]              fill_q, fill_d;
  logic [SLOT_W-1:0]           rd_idx_q, rd_idx_d;
  logic [N_W-1:0]              left_q, left_d;
  logic                        rd_vld_q, rd_vld_d;
  logic signed [ACC_W-1:0]     acc_q, acc_d;
  logic signed [TOTAL_BITS-1:0] total_q, total_d;
  logic signed [MEAN_BITS-1:0] mean_q, mean_d;
  logic                        out_valid_q, out_valid_d;
  logic [TS_BITS-1:0]          ts_out_q;
  logic signed [TOTAL_BITS-1:0] total_out_q;
  logic signed [MEAN_BITS-1:0] mean_out_q;

  // history memory
  logic [SAMPLE_BITS-1:0]      hist_mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic                        wr_en, rd_en;
  logic [SLOT_W-1:0]           wr_slot;

  // combinational helpers
  logic [L_W-1:0]              wl_ext;
  logic [N_W-1:0]              fill_base, fill_new, used;
  logic [SLOT_W-1:0]           slot_base;
  logic signed [EXT_W-1:0]     acc_ext;
  logic signed [TOTAL_BITS-1:0] total_sat;
  logic                        neg;
  total_mag_t                  total_abs, quot;
  logic                        div_start, div_done;
  logic                        out_load;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign div_start  = (state_q == S_SAT);

  // window length clamped to 1..WINDOW_MAX
  assign wl_ext = L_W'(wl_q);

  // store step: a start flag restarts the record at slot zero
  assign fill_base = start_q ? '0 : fill_q;
  assign slot_base = start_q ? '0 : slot_q;
  assign fill_new  = (fill_base == N_W'(WINDOW_MAX)) ? fill_base : fill_base + 1'b1;
  assign used      = (n_q < fill_new) ? n_q : fill_new;

  // total saturated to its field, then sign and magnitude for the divider
  assign acc_ext   = EXT_W'(acc_q);
  assign total_sat = (acc_ext > TOT_MAX) ? TOTAL_BITS'(TOT_MAX) :
                     (acc_ext < TOT_MIN) ? TOTAL_BITS'(TOT_MIN) :
                     TOTAL_BITS'(acc_ext);
  assign neg       = total_q[TOTAL_BITS-1];
  assign total_abs = total_sat[TOTAL_BITS-1] ? (~total_sat + 1'b1) : total_sat;

  assign wr_en   = (state_q == S_STORE);
  assign wr_slot = slot_base;

  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    ts_d        = ts_q;
    start_d     = start_q;
    n_d         = n_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    left_d      = left_q;
    rd_vld_d    = 1'b0;
    rd_en       = 1'b0;
    acc_d       = acc_q;
    total_d     = total_q;
    mean_d      = mean_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sample_d = sample_i;
          ts_d     = time_stamp_i;
          start_d  = start_record_i;
          if (wl_q == '0) begin
            n_d = N_W'(1);
          end else if (wl_ext > L_W'(WINDOW_MAX)) begin
            n_d = N_W'(WINDOW_MAX);
          end else begin
            n_d = N_W'(wl_ext);
          end
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        fill_d   = fill_new;
        slot_d   = (slot_base == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_base + 1'b1;
        rd_idx_d = slot_base;
        left_d   = used;
        acc_d    = '0;
        state_d  = S_READ;
      end
      S_READ: begin
        // one read issued per cycle, newest sample first, read data registered
        if (left_q != '0) begin
          rd_en    = 1'b1;
          rd_vld_d = 1'b1;
          left_d   = left_q - 1'b1;
          rd_idx_d = (rd_idx_q == '0) ? SLOT_W'(WINDOW_MAX - 1) : rd_idx_q - 1'b1;
        end
        if (rd_vld_q) begin
          acc_d = acc_q + ACC_W'(rd_data_q);
        end
        if (left_q == '0 && !rd_vld_q) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        total_d = total_sat;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (!neg) begin
            mean_d = (quot > MEAN_POS_LIM) ? MEAN_MAX : MEAN_BITS'(quot);
          end else begin
            mean_d = (quot > MEAN_NEG_LIM) ? MEAN_MIN : MEAN_BITS'(~quot + 1'b1);
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wl_q        <= WL_RESET;
      slot_q      <= '0;
      fill_q      <= '0;
      left_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      left_q      <= left_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        wl_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    ts_q     <= ts_d;
    start_q  <= start_d;
    n_q      <= n_d;
    rd_idx_q <= rd_idx_d;
    acc_q    <= acc_d;
    total_q  <= total_d;
    mean_q   <= mean_d;
    if (out_load) begin
      ts_out_q    <= ts_q;
      total_out_q <= total_q;
      mean_out_q  <= mean_q;
    end
  end

  // history: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hist_mem[wr_slot] <= sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= hist_mem[rd_idx_q];
    end
  end

  maf_divider #(
    .DVS_W (N_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_abs),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign out_valid_o      = out_valid_q;
  assign time_stamp_out_o = ts_out_q;
  assign window_total_o   = total_out_q;
  assign mean_o           = mean_out_q;

  // checks
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= N_W'(WINDOW_MAX))
    else $error("fill count beyond history depth");

  a_slot_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= SLOT_W'(WINDOW_MAX - 1))
    else $error("write slot outside history");

  a_reads_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (left_q <= n_q))
    else $error("more reads pending than the window holds");

  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_result_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result shown without passing the output step");

endmodule
